FILE: rtl/core/iira_pkg.sv
// ----------------------------------------------------------------------------
// iira_pkg
// shared types, codes and default sizes for the indexed insert/remove array
// ----------------------------------------------------------------------------
package iira_pkg;

    // default sizes handed to the top level parameters
    localparam int DEPTH_DEF  = 64;
    localparam int DATA_W_DEF = 32;

    // fixed transaction field widths
    localparam int FUNC_W   = 3;
    localparam int INDEX_W  = 6;
    localparam int VALUE_W  = 32;
    localparam int LENGTH_W = 7;
    localparam int STATUS_W = 2;

    // operation selector carried by a command transaction
    typedef enum logic [FUNC_W-1:0] {
        FUNC_READ         = 3'd0,
        FUNC_WRITE        = 3'd1,
        FUNC_INSERT       = 3'd2,
        FUNC_REMOVE       = 3'd3,
        FUNC_RESIZE_KEEP  = 3'd4,
        FUNC_RESIZE_CLEAR = 3'd5
    } func_t;

    // result status
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // per-cycle action broadcast to every cell
    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_WRITE  = 3'd1,
        CELL_INSERT = 3'd2,
        CELL_REMOVE = 3'd3,
        CELL_TRUNC  = 3'd4,
        CELL_CLEAR  = 3'd5
    } cell_op_t;

    // control/status bundle from the controller to the top level
    typedef struct packed {
        cell_op_t op;
        logic     rd_en;
        status_t  status;
    } iira_ctl_t;

endpackage

FILE: rtl/core/iira_cmd_if.sv
// ----------------------------------------------------------------------------
// iira_cmd_if
// command channel: valid/ready handshake with one operation per transaction
// ----------------------------------------------------------------------------
interface iira_cmd_if
    import iira_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [INDEX_W-1:0]  index;
    logic [VALUE_W-1:0]  value;
    logic [LENGTH_W-1:0] new_length;

    modport source (
        output valid,
        output func,
        output index,
        output value,
        output new_length,
        input  ready
    );

    modport sink (
        input  valid,
        input  func,
        input  index,
        input  value,
        input  new_length,
        output ready
    );
endinterface

FILE: rtl/core/iira_rsp_if.sv
// ----------------------------------------------------------------------------
// iira_rsp_if
// response channel: valid/ready handshake with one result per transaction
// ----------------------------------------------------------------------------
interface iira_rsp_if
    import iira_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  read_value;
    logic [LENGTH_W-1:0] length;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid,
        output read_value,
        output length,
        output status,
        input  ready
    );

    modport sink (
        input  valid,
        input  read_value,
        input  length,
        input  status,
        output ready
    );
endinterface

FILE: rtl/core/indexed_insert_remove_array.sv
// indexed insert/remove array: a row of DEPTH word cells plus a length register
// response: result valid in the cycle after the command transaction is accepted
// throughput: one command per cycle unless a pending response stalls; every cell
//   loads own, left or right neighbor word in parallel to shift on insert/remove
// reset: asynchronous, active low; all cells cleared to zero, length zero,
//   no response pending
// ----------------------------------------------------------------------------
// indexed_insert_remove_array
// bounded word array with read, write, insert, remove and two resize modes
// ----------------------------------------------------------------------------
module indexed_insert_remove_array
    import iira_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int DATA_W = DATA_W_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    iira_cmd_if.sink   cmd,
    iira_rsp_if.source rsp
);

    // length counts up to DEPTH itself; compares run at the wider of that
    // and the 7-bit new_length transaction field
    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam int POS_W = (LEN_W > LENGTH_W) ? LEN_W : LENGTH_W;

    logic              accept;
    iira_ctl_t         ctl;
    logic [POS_W-1:0]  index_x;
    logic [POS_W-1:0]  new_length_x;
    logic [POS_W-1:0]  bound;
    logic [LEN_W-1:0]  length_next;
    logic [POS_W-1:0]  length_x;
    logic [DATA_W-1:0] value_w;
    logic [DATA_W-1:0] cell_q [DEPTH];
    logic [DATA_W-1:0] rd_word;
    logic [VALUE_W-1:0] rd_value;

    // response register
    logic                rsp_valid_reg;
    logic [VALUE_W-1:0]  read_value_reg;
    logic [LENGTH_W-1:0] length_reg;
    logic [STATUS_W-1:0] status_reg;

    // a new command is taken whenever the response slot is free or draining
    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;

    assign index_x      = POS_W'(cmd.index);
    assign new_length_x = POS_W'(cmd.new_length);

    // fit the 32-bit transaction word to the stored width and back
    generate
        if (DATA_W >= VALUE_W)
        begin : g_wide
            assign value_w  = DATA_W'(cmd.value);
            assign rd_value = rd_word[VALUE_W-1:0];
        end
        else
        begin : g_narrow
            assign value_w  = cmd.value[DATA_W-1:0];
            assign rd_value = VALUE_W'(rd_word);
        end
    endgenerate

    iira_ctrl #(
        .DEPTH (DEPTH),
        .LEN_W (LEN_W),
        .POS_W (POS_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .func        (cmd.func),
        .index       (index_x),
        .new_length  (new_length_x),
        .ctl         (ctl),
        .bound       (bound),
        .length_next (length_next)
    );

    // chain of cells; the ends see zero from the missing neighbor
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DATA_W-1:0] left_w;
            logic [DATA_W-1:0] right_w;

            if (gi == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_left
                assign left_w = cell_q[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_right
                assign right_w = cell_q[gi+1];
            end

            iira_cell #(
                .POS    (gi),
                .POS_W  (POS_W),
                .DATA_W (DATA_W)
            ) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .op    (ctl.op),
                .index (index_x),
                .bound (bound),
                .value (value_w),
                .left  (left_w),
                .right (right_w),
                .data  (cell_q[gi])
            );
        end
    endgenerate

    // read port: each cell gates its word on an index match, results or-ed
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (index_x == POS_W'(i))
            begin
                rd_word = rd_word | cell_q[i];
            end
        end
    end

    assign length_x = POS_W'(length_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // payload of the pending response; length is the value after the operation
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_value_reg <= ctl.rd_en ? rd_value : '0;
            length_reg     <= length_x[LENGTH_W-1:0];
            status_reg     <= ctl.status;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_value = read_value_reg;
    assign rsp.length     = length_reg;
    assign rsp.status     = status_reg;

endmodule

FILE: rtl/core/iira_cell.sv
// ----------------------------------------------------------------------------
// iira_cell
// one storage slot of the array; picks its own, left or right neighbor word
// ----------------------------------------------------------------------------
module iira_cell
    import iira_pkg::*;
#(
    parameter int POS    = 0,
    parameter int POS_W  = 7,
    parameter int DATA_W = DATA_W_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cell_op_t          op,
    input  logic [POS_W-1:0]  index,
    input  logic [POS_W-1:0]  bound,
    input  logic [DATA_W-1:0] value,
    input  logic [DATA_W-1:0] left,
    input  logic [DATA_W-1:0] right,
    output logic [DATA_W-1:0] data
);

    localparam logic [POS_W-1:0] POS_V = POS_W'(POS);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (op)
            CELL_WRITE:
            begin
                if (POS_V == index)
                begin
                    data_next = value;
                end
            end
            // bound is the current length
            CELL_INSERT:
            begin
                if (POS_V == index)
                begin
                    data_next = value;
                end
                else if (POS_V > index && POS_V <= bound)
                begin
                    data_next = left;
                end
            end
            // bound is the last used position
            CELL_REMOVE:
            begin
                if (POS_V == bound)
                begin
                    data_next = '0;
                end
                else if (POS_V >= index && POS_V < bound)
                begin
                    data_next = right;
                end
            end
            // bound is the new length
            CELL_TRUNC:
            begin
                if (POS_V >= bound)
                begin
                    data_next = '0;
                end
            end
            CELL_CLEAR:
            begin
                data_next = '0;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

FILE: rtl/core/iira_ctrl.sv
// ----------------------------------------------------------------------------
// iira_ctrl
// length register and operation check; turns a command into a cell action
// ----------------------------------------------------------------------------
module iira_ctrl
    import iira_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int LEN_W = 7,
    parameter int POS_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [FUNC_W-1:0] func,
    input  logic [POS_W-1:0] index,
    input  logic [POS_W-1:0] new_length,
    output iira_ctl_t        ctl,
    output logic [POS_W-1:0] bound,
    output logic [LEN_W-1:0] length_next
);

    localparam logic [POS_W-1:0] DEPTH_V = POS_W'(DEPTH);
    localparam logic [POS_W-1:0] ONE_V   = POS_W'(1);

    logic [LEN_W-1:0] length_reg;
    logic [POS_W-1:0] len_x;
    logic             in_range;
    logic             update;

    assign len_x    = POS_W'(length_reg);
    assign in_range = (index < len_x);

    always_comb
    begin
        ctl.op      = CELL_HOLD;
        ctl.rd_en   = 1'b0;
        ctl.status  = STATUS_OK;
        bound       = len_x;
        length_next = length_reg;
        update      = 1'b0;
        case (func_t'(func))
            FUNC_READ:
            begin
                if (in_range)
                begin
                    ctl.rd_en = 1'b1;
                end
                else
                begin
                    ctl.status = STATUS_RANGE;
                end
            end
            FUNC_WRITE:
            begin
                if (in_range)
                begin
                    ctl.op = CELL_WRITE;
                end
                else
                begin
                    ctl.status = STATUS_RANGE;
                end
            end
            FUNC_INSERT:
            begin
                if (index > len_x)
                begin
                    ctl.status = STATUS_RANGE;
                end
                else if (len_x >= DEPTH_V)
                begin
                    ctl.status = STATUS_FULL;
                end
                else
                begin
                    ctl.op      = CELL_INSERT;
                    length_next = LEN_W'(len_x + ONE_V);
                    update      = 1'b1;
                end
            end
            FUNC_REMOVE:
            begin
                if (in_range)
                begin
                    ctl.op      = CELL_REMOVE;
                    bound       = len_x - ONE_V;
                    length_next = LEN_W'(len_x - ONE_V);
                    update      = 1'b1;
                end
                else
                begin
                    ctl.status = STATUS_RANGE;
                end
            end
            FUNC_RESIZE_KEEP, FUNC_RESIZE_CLEAR:
            begin
                if (new_length > DEPTH_V)
                begin
                    ctl.status = STATUS_RANGE;
                end
                else
                begin
                    ctl.op      = (func_t'(func) == FUNC_RESIZE_KEEP) ? CELL_TRUNC
                                                                      : CELL_CLEAR;
                    bound       = new_length;
                    length_next = LEN_W'(new_length);
                    update      = 1'b1;
                end
            end
            default:
            begin
                ctl.status = STATUS_RANGE;
            end
        endcase
        // no transaction: cells keep their words
        if (!accept)
        begin
            ctl.op = CELL_HOLD;
            update = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
        end
        else if (update)
        begin
            length_reg <= length_next;
        end
    end

endmodule
